/* hw/rtl/mvsc_pkg.sv */
// Package: shared types, constants and conversion functions of the vertex stream checker.
package mvsc_pkg;

  localparam int unsigned NormalOffset         = 12;
  localparam int unsigned TexcoordOffsetWide   = 24;
  localparam int unsigned TexcoordOffsetNarrow = 20;
  localparam logic [7:0]  WideStrideMin        = 8'd32;
  localparam logic [7:0]  MinStride            = 8'd12;
  localparam logic [15:0] RestartIndex         = 16'hFFFF;
  localparam logic [7:0]  NormalNeed           = 8'(NormalOffset + 8);
  localparam logic [7:0]  TexNeedWide          = 8'(TexcoordOffsetWide + 8);
  localparam logic [7:0]  TexNeedNarrow        = 8'(TexcoordOffsetNarrow + 8);

  typedef enum logic [2:0] {
    RegVertexTotal = 3'd0,
    RegIndexTotal  = 3'd1,
    RegStride      = 3'd2,
    RegVertexStart = 3'd3,
    RegIndexStart  = 3'd4,
    RegBufferBytes = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    KindVertex = 2'd0,
    KindIndex  = 2'd1,
    KindMin    = 2'd2,
    KindMax    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StBadDesc  = 2'd1,
    StNonFinite = 2'd2,
    StIndexRange = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [31:0] word_0;
    logic [31:0] word_1;
    logic [31:0] word_2;
    logic [31:0] word_3;
    logic [31:0] word_4;
    logic [15:0] index_out;
    logic        normal_present;
    logic        texcoord_present;
    logic        run_end;
  } result_t;

  // Convert binary16 to binary32, normalizing subnormals with a priority encoder.
  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic       sgn;
    logic [4:0] ex;
    logic [9:0] man;
    logic [3:0] lz;
    logic [9:0] sh;
    logic [7:0] ex32;
    sgn = h[15];
    ex  = h[14:10];
    man = h[9:0];
    lz  = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (man[i]) lz = 4'(9 - i);
    end
    sh   = 10'(man << (lz + 4'd1));
    ex32 = 8'(113 - 1) - 8'(lz);
    if (ex == 5'd0) begin
      if (man == 10'd0) half_to_single = {sgn, 31'd0};
      else half_to_single = {sgn, ex32, sh, 13'd0};
    end else if (ex == 5'h1F) begin
      half_to_single = {sgn, 8'hFF, man, 13'd0};
    end else begin
      half_to_single = {sgn, 8'({3'd0, ex} + 8'd112), man, 13'd0};
    end
  endfunction

  // Order key: unsigned compare of keys matches float compare, zeros equal.
  function automatic logic [31:0] order_key(input logic [31:0] b);
    if (b[30:0] == 31'd0) order_key = 32'h8000_0000;
    else if (b[31]) order_key = ~b;
    else order_key = b | 32'h8000_0000;
  endfunction

endpackage

/* hw/rtl/mvsc_desc_check.sv */
// Descriptor check: flag that the configured descriptor is invalid.
module mvsc_desc_check
  import mvsc_pkg::*;
(
  input  logic [16:0] vertex_total_i,
  input  logic [23:0] index_total_i,
  input  logic [7:0]  record_stride_i,
  input  logic [31:0] vertex_start_i,
  input  logic [31:0] index_start_i,
  input  logic [31:0] buffer_bytes_i,
  output logic        bad_o
);
  logic [24:0] vspan;
  logic [32:0] vend;
  logic [32:0] iend;

  // Flag a stride below the minimum, a zero count, or either buffer end, taken without wrap, beyond the buffer size.
  always_comb begin
    vspan = {8'd0, vertex_total_i} * {17'd0, record_stride_i};
    vend  = {1'b0, vertex_start_i} + {8'd0, vspan};
    iend  = {1'b0, index_start_i} + {8'd0, index_total_i, 1'b0};
    bad_o = (record_stride_i < MinStride) || (vertex_total_i == '0) ||
            (index_total_i == '0) || (vend > {1'b0, buffer_bytes_i}) ||
            (iend > {1'b0, buffer_bytes_i});
  end
endmodule

/* hw/rtl/mesh_vertex_stream_checker_core.sv */
// Top level: vertex/index stream checker with bounds tracking and half-to-float normals.
// One item is accepted per cycle while the input is not stalled; a vertex or plain index item
// yields one result in the next cycle, and a final index item yields three (index, minima,
// maxima), holding the input off while the bounds results drain from the output register.
// Status is sticky; the descriptor check works on the current configuration, so items
// may follow a configuration write in the very next cycle.
module mesh_vertex_stream_checker_core
  import mvsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [31:0] pos_z_i,
  input  logic [15:0] norm_x_i,
  input  logic [15:0] norm_y_i,
  input  logic [15:0] norm_z_i,
  input  logic [31:0] tex_u_i,
  input  logic [31:0] tex_v_i,
  input  logic [15:0] index_word_i,
  input  logic        final_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [1:0]  status_o,
  output logic [31:0] word_0_o,
  output logic [31:0] word_1_o,
  output logic [31:0] word_2_o,
  output logic [31:0] word_3_o,
  output logic [31:0] word_4_o,
  output logic [15:0] index_out_o,
  output logic        normal_present_o,
  output logic        texcoord_present_o,
  output logic        run_end_o
);
  logic [16:0] vertex_total_q;
  logic [23:0] index_total_q;
  logic [7:0]  record_stride_q;
  logic [31:0] vertex_start_q;
  logic [31:0] index_start_q;
  logic [31:0] buffer_bytes_q;
  logic        desc_bad;

  logic [31:0] min_q [3];
  logic [31:0] max_q [3];
  logic [31:0] min_d [3];
  logic [31:0] max_d [3];
  logic        started_q, started_d;
  logic [1:0]  err_q, err_d;
  logic [1:0]  pend_q, pend_d;   // bounds results still to emit
  logic [31:0] bmin_q [3];
  logic [31:0] bmax_q [3];
  result_t     res_q, res_d;
  logic        ovalid_q, ovalid_d;
  logic        in_acc, out_free;
  logic        np, tp;
  logic [31:0] p [3];
  logic        fin;

  assign cfg_ready_o = 1'b1;

  // Write configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_total_q <= '0; index_total_q <= '0; record_stride_q <= '0;
      vertex_start_q <= '0; index_start_q <= '0; buffer_bytes_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegVertexTotal: vertex_total_q  <= cfg_data_i[16:0];
        RegIndexTotal:  index_total_q   <= cfg_data_i[23:0];
        RegStride:      record_stride_q <= cfg_data_i[7:0];
        RegVertexStart: vertex_start_q  <= cfg_data_i;
        RegIndexStart:  index_start_q   <= cfg_data_i;
        RegBufferBytes: buffer_bytes_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mvsc_desc_check u_desc (
    .vertex_total_i (vertex_total_q),
    .index_total_i  (index_total_q),
    .record_stride_i(record_stride_q),
    .vertex_start_i (vertex_start_q),
    .index_start_i  (index_start_q),
    .buffer_bytes_i (buffer_bytes_q),
    .bad_o          (desc_bad)
  );

  assign np = record_stride_q >= NormalNeed;
  assign tp = record_stride_q >= ((record_stride_q >= WideStrideMin) ? TexNeedWide
                                                                     : TexNeedNarrow);
  assign out_free   = !ovalid_q || !out_stall_i;
  assign in_stall_o = !out_free || (pend_q != 2'd0);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign p[0] = pos_x_i;
  assign p[1] = pos_y_i;
  assign p[2] = pos_z_i;
  assign fin  = op_i && final_item_i;

  // Compute next state and the result of the accepted item.
  always_comb begin
    logic [1:0] e;
    logic       finite;
    min_d = min_q; max_d = max_q; started_d = started_q; err_d = err_q;
    pend_d = pend_q; ovalid_d = ovalid_q; res_d = res_q;
    e = err_q;
    finite = 1'b0;
    if (out_free) ovalid_d = 1'b0;
    if (out_free && pend_q != 2'd0) begin
      ovalid_d = 1'b1;
      res_d = '0;
      res_d.status = err_q;
      res_d.normal_present = np;
      res_d.texcoord_present = tp;
      if (pend_q == 2'd2) begin
        res_d.kind = KindMin;
        res_d.word_0 = bmin_q[0]; res_d.word_1 = bmin_q[1]; res_d.word_2 = bmin_q[2];
      end else begin
        res_d.kind = KindMax;
        res_d.run_end = 1'b1;
        res_d.word_0 = bmax_q[0]; res_d.word_1 = bmax_q[1]; res_d.word_2 = bmax_q[2];
      end
      pend_d = pend_q - 2'd1;
    end else if (in_acc) begin
      if (e == StOk && desc_bad) e = StBadDesc;
      res_d = '0;
      res_d.normal_present = np;
      res_d.texcoord_present = tp;
      if (!op_i) begin
        finite = (p[0][30:23] != 8'hFF) && (p[1][30:23] != 8'hFF) &&
                 (p[2][30:23] != 8'hFF);
        if (finite) begin
          for (int i = 0; i < 3; i++) begin
            if (!started_q) begin
              min_d[i] = p[i]; max_d[i] = p[i];
            end else begin
              if (order_key(p[i]) < order_key(min_q[i])) min_d[i] = p[i];
              if (order_key(p[i]) > order_key(max_q[i])) max_d[i] = p[i];
            end
          end
          started_d = 1'b1;
        end else if (e == StOk) begin
          e = StNonFinite;
        end
        res_d.kind = KindVertex;
        if (np) begin
          res_d.word_0 = half_to_single(norm_x_i);
          res_d.word_1 = half_to_single(norm_y_i);
          res_d.word_2 = half_to_single(norm_z_i);
        end
        if (tp) begin
          res_d.word_3 = tex_u_i;
          res_d.word_4 = tex_v_i;
        end
      end else begin
        if (e == StOk && index_word_i != RestartIndex &&
            {1'b0, index_word_i} >= vertex_total_q) e = StIndexRange;
        res_d.kind = KindIndex;
        res_d.index_out = index_word_i;
        if (final_item_i) begin
          pend_d = 2'd2;
          started_d = 1'b0;
          for (int i = 0; i < 3; i++) begin
            min_d[i] = '0; max_d[i] = '0;
          end
        end
      end
      res_d.status = e;
      err_d = e;
      ovalid_d = 1'b1;
    end
  end

  // Hold state: running bounds, sticky status, pending bounds results and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        min_q[i] <= '0; max_q[i] <= '0;
      end
      started_q <= 1'b0;
      err_q     <= StOk;
      pend_q    <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      min_q     <= min_d;
      max_q     <= max_d;
      started_q <= started_d;
      err_q     <= err_d;
      pend_q    <= pend_d;
      ovalid_q  <= ovalid_d;
    end
  end

  // Register the result and capture the box at the final item; payload needs no reset.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (in_acc && fin) begin
      for (int i = 0; i < 3; i++) begin
        bmin_q[i] <= started_q ? min_q[i] : '0;
        bmax_q[i] <= started_q ? max_q[i] : '0;
      end
    end
  end

  assign out_valid_o        = ovalid_q;
  assign kind_o             = res_q.kind;
  assign status_o           = res_q.status;
  assign word_0_o           = res_q.word_0;
  assign word_1_o           = res_q.word_1;
  assign word_2_o           = res_q.word_2;
  assign word_3_o           = res_q.word_3;
  assign word_4_o           = res_q.word_4;
  assign index_out_o        = res_q.index_out;
  assign normal_present_o   = res_q.normal_present;
  assign texcoord_present_o = res_q.texcoord_present;
  assign run_end_o          = res_q.run_end;

`ifndef SYNTH
  // Sticky status never returns to ok once set.
  a_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != StOk) |=> (err_q != StOk)) else $error("status cleared");
  // No input accepted while bounds results drain.
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q != 2'd0) |-> !in_acc) else $error("accept during drain");
  // Run end only on a maxima result.
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && run_end_o) |-> (kind_o == KindMax)) else $error("bad run end");
`endif
endmodule

/* tb/tb_mesh_vertex_stream_checker_core.sv */
// Testbench: stimulus, bounds/normal predictor and result checks for the vertex stream checker.
`timescale 1ns / 1ps
module tb_mesh_vertex_stream_checker_core;
  import mvsc_pkg::*;

  typedef struct packed {
    logic        op;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [15:0] norm_x;
    logic [15:0] norm_y;
    logic [15:0] norm_z;
    logic [31:0] tex_u;
    logic [31:0] tex_v;
    logic [15:0] index_word;
    logic        final_item;
  } vtx_req_t;

  localparam logic OpVertex = 1'b0;
  localparam logic OpIndex  = 1'b1;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  reg_idx_e    cfg_index = RegVertexTotal;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  vtx_req_t    cur_req = '0;
  logic        cur_has_w0 = 1'b0;
  logic [31:0] cur_w0 = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  result_t     res;

  mesh_vertex_stream_checker_core u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .op_i(cur_req.op), .pos_x_i(cur_req.pos_x), .pos_y_i(cur_req.pos_y),
    .pos_z_i(cur_req.pos_z), .norm_x_i(cur_req.norm_x), .norm_y_i(cur_req.norm_y),
    .norm_z_i(cur_req.norm_z), .tex_u_i(cur_req.tex_u), .tex_v_i(cur_req.tex_v),
    .index_word_i(cur_req.index_word), .final_item_i(cur_req.final_item),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .kind_o(res.kind), .status_o(res.status),
    .word_0_o(res.word_0), .word_1_o(res.word_1), .word_2_o(res.word_2),
    .word_3_o(res.word_3), .word_4_o(res.word_4), .index_out_o(res.index_out),
    .normal_present_o(res.normal_present), .texcoord_present_o(res.texcoord_present),
    .run_end_o(res.run_end)
  );

  // Predictor state and shadow configuration
  logic [31:0] bmin [3];
  logic [31:0] bmax [3];
  logic        box_live;
  logic [1:0]  err_sticky;
  logic [16:0] sh_vtx_total;
  logic [23:0] sh_idx_total;
  logic [7:0]  sh_stride;
  logic [31:0] sh_vtx_start, sh_idx_start, sh_buf_bytes;

  result_t pending_results[$];
  int      fail_count = 0;
  int      req_count = 0;
  int      result_count = 0;
  int      run_count = 0;

  int in_idle_pct = 0;
  int out_stall_pct = 0;
  bit hold_req = 0;
  bit hold_done = 0;
  int hold_cnt = 0;
  bit errors_on = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    #2ms;
    $display("FAIL mesh_vertex_stream_checker_core");
    $finish;
  end

  function automatic logic [31:0] half_to_float(logic [15:0] h);
    logic [10:0] m;
    logic [7:0]  e;
    m = {1'b0, h[9:0]};
    e = 8'd113;
    if (h[14:10] == 5'd0) begin
      if (m == 0) return {h[15], 31'd0};
      while (!m[10]) begin
        m = m << 1;
        e = e - 8'd1;
      end
      return {h[15], e, m[9:0], 13'd0};
    end
    if (h[14:10] == 5'h1F) return {h[15], 8'hFF, h[9:0], 13'd0};
    return {h[15], 8'(h[14:10]) + 8'd112, h[9:0], 13'd0};
  endfunction

  function automatic logic [31:0] sort_key(logic [31:0] b);
    if (b[30:0] == 0) return 32'h8000_0000;
    if (b[31]) return ~b;
    return b | 32'h8000_0000;
  endfunction

  function automatic bit descriptor_broken();
    longint unsigned vend, iend;
    vend = longint'(sh_vtx_start) + longint'(sh_vtx_total) * longint'(sh_stride);
    iend = longint'(sh_idx_start) + 2 * longint'(sh_idx_total);
    return sh_stride < MinStride || sh_vtx_total == 0 || sh_idx_total == 0 ||
           vend > sh_buf_bytes || iend > sh_buf_bytes;
  endfunction

  // Append one expected result at the tail of the queue
  task automatic queue_result(result_t r);
    pending_results.insert(pending_results.size(), r);
  endtask

  // Work out the results of one accepted request and advance the predictor
  task automatic predict_results(vtx_req_t rq, bit has_w0, logic [31:0] w0);
    result_t r;
    logic [31:0] p [3];
    bit np, tp;
    np = sh_stride >= NormalNeed;
    tp = sh_stride >= ((sh_stride >= WideStrideMin) ? TexNeedWide : TexNeedNarrow);
    if (descriptor_broken() && err_sticky == StOk) err_sticky = StBadDesc;
    r = '0;
    r.normal_present = np;
    r.texcoord_present = tp;
    if (rq.op == OpVertex) begin
      p[0] = rq.pos_x; p[1] = rq.pos_y; p[2] = rq.pos_z;
      if (p[0][30:23] != 8'hFF && p[1][30:23] != 8'hFF && p[2][30:23] != 8'hFF) begin
        for (int i = 0; i < 3; i++) begin
          if (!box_live) begin
            bmin[i] = p[i]; bmax[i] = p[i];
          end else begin
            if (sort_key(p[i]) < sort_key(bmin[i])) bmin[i] = p[i];
            if (sort_key(p[i]) > sort_key(bmax[i])) bmax[i] = p[i];
          end
        end
        box_live = 1'b1;
      end else if (err_sticky == StOk) begin
        err_sticky = StNonFinite;
      end
      r.kind = KindVertex;
      r.status = err_sticky;
      if (np) begin
        r.word_0 = half_to_float(rq.norm_x);
        r.word_1 = half_to_float(rq.norm_y);
        r.word_2 = half_to_float(rq.norm_z);
      end
      if (tp) begin
        r.word_3 = rq.tex_u;
        r.word_4 = rq.tex_v;
      end
      if (has_w0) r.word_0 = w0;
      queue_result(r);
      return;
    end
    if (rq.index_word != RestartIndex && 17'(rq.index_word) >= sh_vtx_total &&
        err_sticky == StOk) err_sticky = StIndexRange;
    r.kind = KindIndex;
    r.status = err_sticky;
    r.index_out = rq.index_word;
    queue_result(r);
    if (!rq.final_item) return;
    r.index_out = '0;
    r.kind = KindMin;
    r.word_0 = box_live ? bmin[0] : '0;
    r.word_1 = box_live ? bmin[1] : '0;
    r.word_2 = box_live ? bmin[2] : '0;
    queue_result(r);
    r.kind = KindMax;
    r.run_end = 1'b1;
    r.word_0 = box_live ? bmax[0] : '0;
    r.word_1 = box_live ? bmax[1] : '0;
    r.word_2 = box_live ? bmax[2] : '0;
    queue_result(r);
    for (int i = 0; i < 3; i++) begin
      bmin[i] = '0; bmax[i] = '0;
    end
    box_live = 1'b0;
    run_count++;
  endtask

  task automatic cmp_field(string nm, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, nm, e, a);
      fail_count++;
    end
  endtask

  // Monitor: track config writes, predict on accepted requests, check results
  always @(posedge clk) begin
    result_t e;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegVertexTotal: sh_vtx_total = cfg_data[16:0];
          RegIndexTotal:  sh_idx_total = cfg_data[23:0];
          RegStride:      sh_stride = cfg_data[7:0];
          RegVertexStart: sh_vtx_start = cfg_data;
          RegIndexStart:  sh_idx_start = cfg_data;
          RegBufferBytes: sh_buf_bytes = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_results(cur_req, cur_has_w0, cur_w0);
        req_count++;
      end
      if (out_valid && !out_stall) begin
        result_count++;
        if (pending_results.size() == 0) begin
          $display("%0t unexpected result kind %0d", $time, res.kind);
          fail_count++;
        end else begin
          e = pending_results.pop_front();
          cmp_field("kind", 32'(e.kind), 32'(res.kind));
          cmp_field("status", 32'(e.status), 32'(res.status));
          cmp_field("word_0", e.word_0, res.word_0);
          cmp_field("word_1", e.word_1, res.word_1);
          cmp_field("word_2", e.word_2, res.word_2);
          cmp_field("word_3", e.word_3, res.word_3);
          cmp_field("word_4", e.word_4, res.word_4);
          cmp_field("index_out", 32'(e.index_out), 32'(res.index_out));
          cmp_field("normal_present", 32'(e.normal_present), 32'(res.normal_present));
          cmp_field("texcoord_present", 32'(e.texcoord_present),
                    32'(res.texcoord_present));
          cmp_field("run_end", 32'(e.run_end), 32'(res.run_end));
        end
      end
    end
  end

  // Receiver: random stall, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt <= 80;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end
  end

  // Drive one request, idling first at random, and hold it until accepted
  task automatic send_req(vtx_req_t rq, bit has_w0 = 0, logic [31:0] w0 = '0);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 99) < in_idle_pct) begin
        in_valid <= 1'b0;
      end else begin
        cur_req <= rq;
        cur_has_w0 <= has_w0;
        cur_w0 <= w0;
        in_valid <= 1'b1;
        break;
      end
    end
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_descriptor(logic [31:0] vt, logic [31:0] it, logic [31:0] st,
                                  logic [31:0] vs, logic [31:0] is, logic [31:0] bb);
    logic [31:0] vals [6];
    vals = '{vt, it, st, vs, is, bb};
    for (int i = 0; i < 6; i++) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= reg_idx_e'(i);
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    repeat (3) @(posedge clk);
  endtask

  // Drop valid and wait until every expected result has drained
  task automatic drain();
    int guard;
    guard = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_pos();
    int r;
    r = $urandom_range(0, 99);
    if (errors_on && r < 3) return {1'($urandom), 8'hFF, 23'($urandom)};
    if (r < 12) return {1'($urandom), 31'd0};
    return {1'($urandom), 8'($urandom_range(0, 254)), 23'($urandom)};
  endfunction

  function automatic logic [15:0] rand_half();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return {1'($urandom), 5'd0, 10'($urandom)};
    if (r < 30) return {1'($urandom), 5'h1F, 10'($urandom)};
    return 16'($urandom);
  endfunction

  function automatic vtx_req_t rand_vertex();
    vtx_req_t rq;
    rq = '{op: OpVertex, pos_x: rand_pos(), pos_y: rand_pos(), pos_z: rand_pos(),
           norm_x: rand_half(), norm_y: rand_half(), norm_z: rand_half(),
           tex_u: $urandom, tex_v: $urandom, index_word: 16'($urandom),
           final_item: 1'($urandom)};
    return rq;
  endfunction

  function automatic vtx_req_t rand_index(bit fin);
    vtx_req_t rq;
    int top;
    rq = rand_vertex();
    rq.op = OpIndex;
    rq.final_item = fin;
    top = (sh_vtx_total > 65535) ? 65535 : int'(sh_vtx_total) - 1;
    if (errors_on && $urandom_range(0, 9) == 0) rq.index_word = 16'($urandom);
    else if ($urandom_range(0, 7) == 0 || top < 0) rq.index_word = RestartIndex;
    else rq.index_word = 16'($urandom_range(0, top));
    return rq;
  endfunction

  // Random meshes: vertices, then indices closed by a final word; some noise
  task automatic run_meshes(int target);
    int start, nv, ni;
    vtx_req_t rq;
    start = req_count;
    while (req_count - start < target) begin
      if ($urandom_range(0, 7) == 0) begin
        rq = $urandom_range(0, 1) ? rand_vertex() : rand_index(1'($urandom));
        send_req(rq);
      end else begin
        nv = $urandom_range(1, 6);
        ni = $urandom_range(1, 6);
        repeat (nv) send_req(rand_vertex());
        for (int i = 0; i < ni; i++) send_req(rand_index(i == ni - 1));
      end
    end
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
      1: begin in_idle_pct = 63; out_stall_pct = 0;  end
      2: begin in_idle_pct = 0;  out_stall_pct = 63; end
      default: begin in_idle_pct = 34; out_stall_pct = 34; end
    endcase
  endtask

  task automatic directed_row(logic op, logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                              logic [15:0] nx, logic [15:0] idx, logic fin,
                              bit has_w0, logic [31:0] w0);
    vtx_req_t rq;
    rq = '{op: op, pos_x: px, pos_y: py, pos_z: pz, norm_x: nx, norm_y: 16'h3C00,
           norm_z: 16'h0000, tex_u: 32'hFFFF_FFFF, tex_v: 32'h0000_0000,
           index_word: idx, final_item: fin};
    send_req(rq, has_w0, w0);
  endtask

  initial begin
    for (int i = 0; i < 3; i++) begin
      bmin[i] = '0; bmax[i] = '0;
    end
    box_live = 1'b0;
    err_sticky = StOk;
    sh_vtx_total = '0; sh_idx_total = '0; sh_stride = '0;
    sh_vtx_start = '0; sh_idx_start = '0; sh_buf_bytes = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed: wide stride, both attributes present, a vertex total of sixteen
    write_descriptor(16, 64, 32, 0, 32'h1000, 32'hFFFF_FFFF);
    directed_row(OpVertex, 32'h3F80_0000, 32'h4000_0000, 32'h4040_0000, 16'h3C00,
                 0, 0, 1, 32'h3F80_0000);
    directed_row(OpVertex, 32'h8000_0000, 32'h0000_0000, 32'h0000_0001, 16'h0001,
                 0, 0, 1, 32'h3380_0000);
    directed_row(OpVertex, 32'hFF7F_FFFF, 32'h7F7F_FFFF, 32'h8000_0001, 16'h03FF,
                 0, 0, 1, 32'h387F_C000);
    directed_row(OpVertex, 32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 16'h7C00,
                 0, 0, 1, 32'h7F80_0000);
    directed_row(OpVertex, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0080_0000, 16'hFC00,
                 0, 0, 1, 32'hFF80_0000);
    directed_row(OpVertex, 32'h3F00_0000, 32'h0, 32'h0, 16'h7E00, 0, 0, 1, 32'h7FC0_0000);
    directed_row(OpVertex, 32'h0, 32'h0, 32'h0, 16'h8000, 0, 1, 1, 32'h8000_0000);
    directed_row(OpVertex, 32'h0, 32'h0, 32'h0, 16'hFFFF, 0, 0, 1, 32'hFFFF_E000);
    directed_row(OpVertex, 32'h0, 32'h0, 32'h0, 16'h7BFF, 0, 0, 1, 32'h477F_E000);
    directed_row(OpIndex, 0, 0, 0, 0, 16'd0, 0, 0, 0);
    directed_row(OpIndex, 0, 0, 0, 0, 16'd15, 0, 0, 0);
    directed_row(OpIndex, 0, 0, 0, 0, RestartIndex, 0, 0, 0);
    directed_row(OpIndex, 0, 0, 0, 0, 16'd15, 1, 0, 0);
    // Final word with an empty box: bounds come out as zero
    directed_row(OpIndex, 0, 0, 0, 0, 16'd3, 1, 0, 0);
    directed_row(OpVertex, 32'hBF80_0000, 32'h0, 32'h0, 16'h3555, 0, 0, 0, 0);
    directed_row(OpIndex, 0, 0, 0, 0, 16'd7, 1, 0, 0);
    drain();

    // Largest index count and stride, no idling
    write_descriptor(32'h1_0000, 32'hFF_FFFF, 255, 0, 0, 32'hFFFF_FFFF);
    set_idling(0);
    run_meshes(60);
    drain();

    // Normal only, sender idling, with a long receiver hold-off
    write_descriptor(12, 100, 20, 32'h100, 32'h200, 32'h1_0000);
    set_idling(1);
    hold_req = 1;
    run_meshes(60);
    drain();

    // Narrow texture layout, receiver stalling
    write_descriptor(9, 50, 28, 0, 0, 1000);
    set_idling(2);
    run_meshes(60);
    drain();

    // Minimum stride, no attributes, both sides idling
    write_descriptor(5, 10, 12, 0, 0, 100);
    set_idling(3);
    run_meshes(60);
    drain();

    // Error injection: non-finite positions and stray indices
    write_descriptor(8, 40, 24, 0, 0, 32'hFFFF_FFFF);
    errors_on = 1;
    for (int m = 0; m < 4; m++) begin
      set_idling(m);
      run_meshes(25);
    end
    drain();

    // Broken descriptor at the far extremes
    write_descriptor(3, 0, 11, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    set_idling(3);
    run_meshes(25);
    drain();

    $display("Covered %0d requests, %0d results, %0d bounds runs over seven descriptors",
             req_count, result_count, run_count);
    $display("Idling phases, receiver hold-off and sticky error paths exercised");
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("PASS mesh_vertex_stream_checker_core");
    end else begin
      $display("FAIL mesh_vertex_stream_checker_core");
    end
    $finish;
  end

endmodule
